/* hw/rtl/rfa_pkg.sv */
// rfa_pkg: shared types and constants for the rational fraction alu
// depends on nothing; used by rfa_ctrl, rfa_dp and the top level
package rfa_pkg;

  // result range: signed numerator of FIELD_WIDTH bits, denominator below 2^(FIELD_WIDTH-1)
  localparam int FIELD_WIDTH = 32;
  localparam logic [63:0] RES_LIM = (64'd1 << (FIELD_WIDTH - 1)) - 64'd1;

  // operation codes
  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_CMP = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       mul;
    logic [1:0] idx;
    logic       comb;
    logic       ginit;
    logic       gstep;
    logic       gfin;
    logic       dinit;
    logic       dstep;
    logic       dstore;
    logic       dsel;
    logic       fin;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic skip;
    logic gcd_done;
  } sts_t;

endpackage

/* hw/rtl/rfa_dp.sv */
// rfa_dp: datapath of the rational fraction alu (multiplier, combine, gcd, divider)
// depends on rfa_pkg; driven by rfa_ctrl commands
module rfa_dp (
  input  logic              clk,
  input  rfa_pkg::cmd_t     cmd,
  output rfa_pkg::sts_t     sts,
  input  logic [2:0]        in_mode,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic signed [31:0] out_res_num,
  output logic [30:0]       out_res_den,
  output logic [1:0]        out_status,
  output logic              out_greater,
  output logic              out_equal,
  output logic              out_less
);
  import rfa_pkg::*;

  logic [2:0]  mode_r;
  logic        zden_r, bnz_r;
  logic        as_r, bs_r;
  logic [31:0] am_r, adm_r, bm_r, bdm_r;
  logic [63:0] pa_r, pb_r, pc_r, pd_r;
  logic [63:0] nmag_r, dmag_r;
  logic        neg_r, have_r;
  logic [1:0]  status_r;
  logic        gt_r, eq_r, lt_r;
  logic [63:0] x_r, y_r, g_r;
  logic [6:0]  k_r;
  logic [63:0] q_r, rem_r;
  logic signed [31:0] res_num_r;
  logic [30:0] res_den_r;
  logic [1:0]  res_status_r;
  logic        res_gt_r, res_eq_r, res_lt_r;

  // operand magnitudes with signs folded onto the numerators
  logic [31:0] am_nxt, adm_nxt, bm_nxt, bdm_nxt;
  always_comb begin
    am_nxt  = in_a_num[31] ? 32'd0 - in_a_num : in_a_num;
    adm_nxt = in_a_den[31] ? 32'd0 - in_a_den : in_a_den;
    bm_nxt  = in_b_num[31] ? 32'd0 - in_b_num : in_b_num;
    bdm_nxt = in_b_den[31] ? 32'd0 - in_b_den : in_b_den;
  end

  // shared multiplier operand select
  logic [31:0] mx, my;
  logic [63:0] prod;
  always_comb begin
    unique case (cmd.idx)
      2'd0: begin mx = am_r;  my = bdm_r; end
      2'd1: begin mx = adm_r; my = bm_r;  end
      2'd2: begin mx = adm_r; my = bdm_r; end
      default: begin mx = am_r; my = bm_r; end
    endcase
    prod = 64'(mx) * 64'(my);
  end

  // sign-magnitude sum of cross products
  logic        sb_eff, same, ge, sneg;
  logic [63:0] sum;
  always_comb begin
    sb_eff = bs_r ^ (mode_r != MODE_ADD);
    same   = (as_r == sb_eff);
    ge     = (pa_r >= pb_r);
    if (same) begin
      sum  = pa_r + pb_r;
      sneg = as_r;
    end else if (ge) begin
      sum  = pa_r - pb_r;
      sneg = as_r;
    end else begin
      sum  = pb_r - pa_r;
      sneg = sb_eff;
    end
    sneg = sneg && (sum != 64'd0);
  end

  // combine step results
  logic [63:0] n_c, d_c;
  logic        neg_c, have_c, gt_c, eq_c, lt_c;
  logic [1:0]  st_c;
  always_comb begin
    n_c = 64'd0; d_c = 64'd1; neg_c = 1'b0; have_c = 1'b0;
    gt_c = 1'b0; eq_c = 1'b0; lt_c = 1'b0; st_c = ST_OK;
    if (zden_r && mode_r <= MODE_CMP) begin
      st_c = ST_ZDEN;
    end else begin
      unique case (mode_r)
        MODE_ADD, MODE_SUB: begin
          n_c = sum; neg_c = sneg; d_c = pc_r; have_c = 1'b1;
        end
        MODE_MUL: begin
          n_c = pd_r; neg_c = (pd_r != 64'd0) && (as_r ^ bs_r); d_c = pc_r; have_c = 1'b1;
        end
        MODE_DIV: begin
          if (!bnz_r) begin
            st_c = ST_ZDEN;
          end else begin
            n_c = pa_r; neg_c = (pa_r != 64'd0) && (as_r ^ bs_r); d_c = pb_r; have_c = 1'b1;
          end
        end
        MODE_CMP: begin
          eq_c = (sum == 64'd0);
          lt_c = (sum != 64'd0) && sneg;
          gt_c = (sum != 64'd0) && !sneg;
        end
        default: ;
      endcase
    end
    // zero result needs no reduction
    have_c = have_c && (n_c != 64'd0);
  end

  // divider step
  logic [64:0] rr;
  logic [64:0] rdiff;
  always_comb begin
    rr    = {rem_r, q_r[63]};
    rdiff = rr - {1'b0, g_r};
  end

  // overflow check on the reduced result
  logic over;
  always_comb begin
    over = (nmag_r > (RES_LIM + {63'd0, neg_r})) || (dmag_r > RES_LIM);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      zden_r <= (in_a_den == 32'sd0) || (in_b_den == 32'sd0);
      bnz_r  <= (in_b_num != 32'sd0);
      as_r   <= (in_a_num != 32'sd0) && (in_a_num[31] ^ in_a_den[31]);
      bs_r   <= (in_b_num != 32'sd0) && (in_b_num[31] ^ in_b_den[31]);
      am_r   <= am_nxt;
      adm_r  <= adm_nxt;
      bm_r   <= bm_nxt;
      bdm_r  <= bdm_nxt;
    end
    if (cmd.mul) begin
      unique case (cmd.idx)
        2'd0: pa_r <= prod;
        2'd1: pb_r <= prod;
        2'd2: pc_r <= prod;
        default: pd_r <= prod;
      endcase
    end
    if (cmd.comb) begin
      nmag_r   <= n_c;
      dmag_r   <= d_c;
      neg_r    <= neg_c;
      have_r   <= have_c;
      status_r <= st_c;
      gt_r     <= gt_c;
      eq_r     <= eq_c;
      lt_r     <= lt_c;
    end
    // binary gcd
    if (cmd.ginit) begin
      x_r <= nmag_r;
      y_r <= dmag_r;
      k_r <= 7'd0;
    end else if (cmd.gstep) begin
      priority if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + 7'd1;
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= x_r - y_r;
      end else begin
        y_r <= y_r - x_r;
      end
    end
    if (cmd.gfin) g_r <= (x_r | y_r) << k_r[5:0];
    // restoring division, one quotient bit per cycle
    if (cmd.dinit) begin
      q_r   <= cmd.dsel ? dmag_r : nmag_r;
      rem_r <= 64'd0;
    end else if (cmd.dstep) begin
      if (!rdiff[64]) begin
        rem_r <= rdiff[63:0];
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= rr[63:0];
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
    if (cmd.dstore) begin
      if (cmd.dsel) dmag_r <= q_r;
      else nmag_r <= q_r;
    end
    // result register
    if (cmd.fin) begin
      res_gt_r <= gt_r;
      res_eq_r <= eq_r;
      res_lt_r <= lt_r;
      if (have_r && !over) begin
        res_num_r    <= neg_r ? 32'sd0 - $signed(nmag_r[31:0]) : $signed(nmag_r[31:0]);
        res_den_r    <= dmag_r[30:0];
        res_status_r <= ST_OK;
      end else begin
        res_num_r    <= 32'sd0;
        res_den_r    <= 31'd1;
        res_status_r <= have_r ? ST_OVF : status_r;
      end
    end
  end

  assign sts.skip     = !have_r;
  assign sts.gcd_done = (x_r == 64'd0) || (y_r == 64'd0);

  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_status  = res_status_r;
  assign out_greater = res_gt_r;
  assign out_equal   = res_eq_r;
  assign out_less    = res_lt_r;

endmodule

/* hw/rtl/rfa_ctrl.sv */
// rfa_ctrl: sequencing state machine and handshake control
// depends on rfa_pkg; commands rfa_dp
module rfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rfa_pkg::cmd_t cmd,
  input  rfa_pkg::sts_t sts
);
  import rfa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_COMB  = 4'd2;
  localparam logic [3:0] S_GINIT = 4'd3;
  localparam logic [3:0] S_GCD   = 4'd4;
  localparam logic [3:0] S_DIVI  = 4'd5;
  localparam logic [3:0] S_DIVS  = 4'd6;
  localparam logic [3:0] S_DSTO  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       sel_r, sel_nxt;
  logic       ovld_r, ovld_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    ovld_nxt  = ovld_r && !out_ready;
    cmd       = '0;
    cmd.idx   = cnt_r[1:0];
    cmd.dsel  = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 6'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.comb  = 1'b1;
        state_nxt = S_GINIT;
      end
      S_GINIT: begin
        if (sts.skip) begin
          state_nxt = S_FIN;
        end else begin
          cmd.ginit = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.gfin  = 1'b1;
          sel_nxt   = 1'b0;
          state_nxt = S_DIVI;
        end else begin
          cmd.gstep = 1'b1;
        end
      end
      S_DIVI: begin
        cmd.dinit = 1'b1;
        cnt_nxt   = 6'd0;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.dstep = 1'b1;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_DSTO;
      end
      S_DSTO: begin
        cmd.dstore = 1'b1;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_DIVI;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ovld_r || out_ready) begin
          cmd.fin   = 1'b1;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 6'd0;
      sel_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;

endmodule

/* hw/rtl/rational_fraction_alu_core.sv */
// Exact add, subtract, multiply, divide and compare of two signed 32-bit fractions.
// One transaction is worked at a time: the cross products on one shared 32x32 multiplier,
// a binary gcd at one step per cycle, then two restoring divisions by the gcd; the
// time per transaction is set mainly by the gcd loop and the divider. Errors and compares
// skip the reduction. The result sits in an output register, so a new transaction
// is taken while the previous result still waits. Depends on rfa_pkg, rfa_ctrl, rfa_dp.
module rational_fraction_alu_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_status,
  output logic               out_greater,
  output logic               out_equal,
  output logic               out_less
);
  import rfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  rfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic
  rfa_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (in_mode),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status),
    .out_greater (out_greater),
    .out_equal   (out_equal),
    .out_less    (out_less)
  );

endmodule

/* dv/rfa_checker.sv */
// rfa_checker: watches both channels of rational_fraction_alu_core, predicts each result
// and compares it field by field; depends on rfa_pkg for mode and status codes
`timescale 1ns / 1ps

module rfa_checker
  import rfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_res_num,
  input  logic [30:0]        out_res_den,
  input  logic [1:0]         out_status,
  input  logic               out_greater,
  input  logic               out_equal,
  input  logic               out_less,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         status;
    logic               gt;
    logic               eq;
    logic               lt;
  } fraction_res_t;

  fraction_res_t expected_q[$];

  // magnitude of a 64-bit signed value
  function automatic logic [63:0] mag(input logic signed [63:0] x);
    mag = x[63] ? -x : x;
  endfunction

  function automatic logic [63:0] gcd(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] r;
    while (q != 0) begin
      r = p % q;
      p = q;
      q = r;
    end
    gcd = p;
  endfunction

  // exact fraction arithmetic with reduction and range check
  function automatic fraction_res_t fraction_op(input logic [2:0] mode,
      input logic signed [31:0] an32, input logic signed [31:0] ad32,
      input logic signed [31:0] bn32, input logic signed [31:0] bd32);
    fraction_res_t r;
    logic signed [63:0] an, ad, bn, bd;
    logic signed [64:0] diff;
    logic [63:0] nmag, dmag, g, nlim;
    logic neg, reduce;
    r = '{num: 0, den: 1, status: ST_OK, gt: 0, eq: 0, lt: 0};
    an = an32; ad = ad32; bn = bn32; bd = bd32;
    reduce = 1'b1;
    neg = 1'b0;
    nmag = 0;
    dmag = 1;
    if (mode > MODE_CMP) return r;
    if (ad == 0 || bd == 0) begin
      r.status = ST_ZDEN;
      return r;
    end
    if (ad < 0) begin ad = -ad; an = -an; end
    if (bd < 0) begin bd = -bd; bn = -bn; end
    // products fit in 64 bits, their sums need 65
    case (mode)
      MODE_ADD: begin
        diff = 65'(an * bd) + 65'(ad * bn);
        neg = diff < 0; nmag = diff[64] ? 64'(-diff) : diff[63:0]; dmag = ad * bd;
      end
      MODE_SUB: begin
        diff = 65'(an * bd) - 65'(ad * bn);
        neg = diff < 0; nmag = diff[64] ? 64'(-diff) : diff[63:0]; dmag = ad * bd;
      end
      MODE_MUL: begin
        nmag = mag(an * bn);
        neg = (nmag != 0) && ((an < 0) != (bn < 0));
        dmag = ad * bd;
      end
      MODE_DIV: begin
        if (bn == 0) begin
          r.status = ST_ZDEN;
          return r;
        end
        nmag = mag(an * bd);
        neg = (nmag != 0) && ((an < 0) != (bn < 0));
        dmag = mag(ad * bn);
      end
      default: begin
        diff = 65'(an * bd) - 65'(ad * bn);
        r.eq = diff == 0;
        r.lt = diff < 0;
        r.gt = diff > 0;
        reduce = 1'b0;
      end
    endcase
    if (reduce) begin
      if (nmag == 0) begin
        dmag = 1;
        neg = 1'b0;
      end else begin
        g = gcd(nmag, dmag);
        nmag = nmag / g;
        dmag = dmag / g;
      end
      nlim = neg ? RES_LIM + 1 : RES_LIM;
      if (nmag > nlim || dmag > RES_LIM) r.status = ST_OVF;
      else begin
        r.num = neg ? -nmag[31:0] : nmag[31:0];
        r.den = dmag[30:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h", result_count, what, got,
      want);
    fail_count++;
  endtask

  assign pending = expected_q.size();

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    fraction_res_t want;
    if (!rst_n) begin
      fail_count = 0;
      result_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(fraction_op(in_mode, in_a_num, in_a_den, in_b_num, in_b_den));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 32'(out_res_num), 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_res_num !== want.num) report_mismatch("res_num", out_res_num, want.num);
          if (out_res_den !== want.den)
            report_mismatch("res_den", 32'(out_res_den), 32'(want.den));
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_greater !== want.gt)
            report_mismatch("greater", 32'(out_greater), 32'(want.gt));
          if (out_equal !== want.eq)
            report_mismatch("equal", 32'(out_equal), 32'(want.eq));
          if (out_less !== want.lt)
            report_mismatch("less", 32'(out_less), 32'(want.lt));
        end
      end
    end
  end

endmodule

/* dv/testbench.sv */
// testbench: drives directed and random fraction transactions into
// rational_fraction_alu_core and gives the verdict; depends on rfa_pkg and rfa_checker
`timescale 1ns / 1ps

module testbench;
  import rfa_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam longint CYCLE_LIMIT = 4000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_mode = '0;
  logic signed [31:0] in_a_num = '0;
  logic signed [31:0] in_a_den = '0;
  logic signed [31:0] in_b_num = '0;
  logic signed [31:0] in_b_den = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic [1:0]         out_status;
  logic               out_greater;
  logic               out_equal;
  logic               out_less;
  int                 fail_count;
  int                 pending;
  int                 result_count;
  longint             cycle_count = 0;
  int                 hold_cycles = 0;
  bit                 quiet = 1'b0;
  bit                 sent_all = 1'b0;
  int                 sent_count = 0;

  always #10 clk = ~clk;

  rational_fraction_alu_core i_dut (.*);

  rfa_checker i_checker (.*);

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (sent_count >= 300 && sent_count < 310 && hold_cycles == 0) begin
      hold_cycles <= 3000;
      out_ready <= 1'b0;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      if (hold_cycles == 1) hold_cycles <= -1;
      out_ready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  // random operand with a bias toward extremes and small values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: pick_value = 32'h8000_0000;
      1: pick_value = 32'h7fff_ffff;
      2: pick_value = $urandom_range(2) - 1;
      3, 4: pick_value = $urandom_range(40) - 20;
      5, 6: pick_value = $urandom_range(2000) - 1000;
      7: pick_value = $urandom & 32'h0000_ffff;
      default: pick_value = $urandom;
    endcase
  endfunction

  task automatic send(input logic [2:0] mode, input logic [31:0] an, input logic [31:0] ad,
      input logic [31:0] bn, input logic [31:0] bd);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [2:0] mode;
    logic [31:0] ad, bd;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every mode, extremes, zero denominators, divide by zero, overflow
    send(MODE_ADD, 1, 2, 1, 3);
    send(MODE_SUB, 1, 2, 1, 2);
    send(MODE_MUL, -3, 4, 8, -9);
    send(MODE_DIV, 2, 3, -4, 5);
    send(MODE_CMP, 1, 3, 1, 2);
    send(MODE_CMP, 2, 4, -1, -2);
    send(MODE_CMP, 5, 1, -7, 1);
    send(MODE_ADD, 1, 0, 1, 1);
    send(MODE_CMP, 1, 1, 1, 0);
    send(MODE_DIV, 3, 7, 0, 5);
    send(MODE_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    send(MODE_MUL, 32'h8000_0000, 1, 1, 1);
    send(MODE_MUL, 32'h8000_0000, 1, 1, -1);
    send(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send(MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send(MODE_MUL, 1, 32'h7fff_ffff, 1, 2);
    send(MODE_ADD, 0, -5, 0, 7);
    send(3'd5, 1, 1, 1, 1);
    send(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(MODE_CMP, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);

    // pause until all results are back
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    // random: mostly valid modes, a long stretch without sender gaps
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 500 && i < 700);
      if (!quiet && $urandom_range(99) < 7) begin
        repeat ($urandom_range(1, 4)) idle_sender();
      end
      mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      ad = pick_value();
      bd = pick_value();
      if ($urandom_range(29) != 0 && ad == 0) ad = 1;
      if ($urandom_range(29) != 0 && bd == 0) bd = 1;
      send(mode, pick_value(), ad, pick_value(), bd);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;
    sent_all = 1'b1;

    do @(posedge clk); while (pending != 0);
    repeat (500) @(posedge clk);

    $display("covered %0d transactions over all modes, %0d results checked", sent_count,
      result_count);
    $display("included zero denominators, extreme operands, overflows and a long out stall");
    if (fail_count == 0 && pending == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rfa_pkg.sv
hw/rtl/rfa_dp.sv
hw/rtl/rfa_ctrl.sv
hw/rtl/rational_fraction_alu_core.sv
dv/rfa_checker.sv
dv/testbench.sv
